// File: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNTERM     = 3'd1;
  localparam logic [2:0] ERR_CTRL       = 3'd2;
  localparam logic [2:0] ERR_ESCAPE     = 3'd3;
  localparam logic [2:0] ERR_HEX        = 3'd4;
  localparam logic [2:0] ERR_SURROGATE  = 3'd5;
  localparam logic [2:0] ERR_UTF8       = 3'd6;

  // Record handed from the scanner to the emitter: up to four data bytes,
  // optionally followed by one close or error record.
  typedef struct packed {
    logic [2:0]  n_bytes;   // 0..4
    logic [3:0][7:0] bytes;
    logic        has_tail;
    logic [1:0]  tail_kind;
    logic [2:0]  err_code;
    logic [31:0] err_offset;
    logic [31:0] length;
    logic        had_escape;
  } jsu_cmd_t;

  typedef enum logic [7:0] {
    M_IDLE = 8'b0000_0001,
    M_BODY = 8'b0000_0010,
    M_ESC  = 8'b0000_0100,
    M_HEX1 = 8'b0000_1000,
    M_BS2  = 8'b0001_0000,
    M_U2   = 8'b0010_0000,
    M_HEX2 = 8'b0100_0000,
    M_UTF8 = 8'b1000_0000
  } mode_e;

endpackage

`default_nettype wire

// File: rtl/core/json_string_unescaper.sv
// Path: results go through the four-record queue, then the output register;
// a record of up to four bytes plus a close/error item drains at one item a
// cycle while the output is taken. Throughput: one input byte a cycle while
// the queue has room, set by the one-step scanner; bursts wait in the queue.
// Reset: asynchronous, active low; scanner idle awaiting quote, queue empty.
// ----------------------------------------------------------------------------
// json_string_unescaper
// Top level: JSON string unescape with strict UTF-8 checking.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescaper import jsu_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic [7:0]             in_byte_i,
  input  wire logic [OFFSET_BITS-1:0] in_offset_i,
  input  wire logic                   end_of_input_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [1:0]             result_kind_o,
  output      logic [7:0]             out_byte_o,
  output      logic [2:0]             error_code_o,
  output      logic [31:0]            error_offset_o,
  output      logic [31:0]            decoded_length_o,
  output      logic                   had_escape_o,
  output      logic                   last_o
);

  logic     step, push, full, empty, pop;
  jsu_cmd_t cmd, head;

  // Take a byte whenever the queue has room for the record it may cause.
  assign in_ready_o = !full;
  assign step = in_valid_i && in_ready_o;

  jsu_scanner #(.OffsetBits(OFFSET_BITS)) u_scan (
    .clk_i, .rst_ni, .step_i(step), .byte_i(in_byte_i), .offset_i(in_offset_i),
    .eoi_i(end_of_input_i), .cmd_valid_o(push), .cmd_o(cmd)
  );

  jsu_queue #(.Depth(4)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd), .full_o(full),
    .empty_o(empty), .pop_i(pop), .data_o(head)
  );

  jsu_emitter u_emit (
    .clk_i, .rst_ni, .cmd_valid_i(!empty), .cmd_i(head), .cmd_pop_o(pop),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .result_kind_o,
    .out_byte_o, .error_code_o, .error_offset_o, .decoded_length_o,
    .had_escape_o, .last_o
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("record pushed into full queue");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_kind_o != 2'd3))
    else $error("invalid result kind");
  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_DATA) |-> (error_code_o == ERR_NONE))
    else $error("data item with error code");
`endif

endmodule

`default_nettype wire

// File: rtl/core/jsu_scanner.sv
// ----------------------------------------------------------------------------
// jsu_scanner
// Front part: takes one raw byte an item and produces at most one work record.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_scanner import jsu_pkg::*; #(
  parameter int OffsetBits = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [7:0]            byte_i,
  input  wire logic [OffsetBits-1:0] offset_i,
  input  wire logic                  eoi_i,
  output      logic                  cmd_valid_o,
  output      jsu_cmd_t              cmd_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [9:0]  hs_q, hs_d;
  logic [7:0]  lead_q, lead_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  rem_q, rem_d;
  logic [31:0] open_q, open_d, mark_q, mark_d, len_q, len_d;
  logic        esc_q, esc_d;

  logic [31:0] off32;
  logic [3:0]  hv;
  logic        hok;
  logic [15:0] hnew;
  logic [20:0] cp;
  logic        emit_cp;
  logic [1:0]  llen_in, llen_q;
  logic        sec_ok;
  logic [7:0]  lo_b, hi_b;

  // Sign-free zero-extend or truncate the offset to 32 result bits.
  always_comb begin
    off32 = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < OffsetBits) off32[i] = offset_i[i];
    end
  end

  function automatic logic [1:0] lead_len(input logic [7:0] l);
    // 1 -> two bytes, 2 -> three, 3 -> four, 0 invalid
    if (l >= 8'hC2 && l <= 8'hDF) return 2'd1;
    if (l >= 8'hE0 && l <= 8'hEF) return 2'd2;
    if (l >= 8'hF0 && l <= 8'hF4) return 2'd3;
    return 2'd0;
  endfunction

  assign llen_in = lead_len(byte_i);
  assign llen_q  = lead_len(lead_q);

  always_comb begin
    hok = 1'b1;
    hv  = 4'd0;
    if (byte_i >= "0" && byte_i <= "9") hv = 4'(byte_i - 8'h30);
    else if (byte_i >= "a" && byte_i <= "f") hv = 4'(byte_i - 8'h57);
    else if (byte_i >= "A" && byte_i <= "F") hv = 4'(byte_i - 8'h37);
    else hok = 1'b0;
    if (eoi_i) hok = 1'b0;
  end
  assign hnew = {hex_q[11:0], hv};

  always_comb begin
    lo_b = 8'h80;
    hi_b = 8'hBF;
    case (lead_q)
      8'hE0:   lo_b = 8'hA0;
      8'hED:   hi_b = 8'h9F;
      8'hF0:   lo_b = 8'h90;
      8'hF4:   hi_b = 8'h8F;
      default: ;
    endcase
    sec_ok = (byte_i >= lo_b) && (byte_i <= hi_b);
  end

  always_comb begin
    mode_d = mode_q; hex_d = hex_q; hcnt_d = hcnt_q; hs_d = hs_q;
    lead_d = lead_q; held_d = held_q; rem_d = rem_q;
    open_d = open_q; mark_d = mark_q; len_d = len_q; esc_d = esc_q;
    cmd_o = '0;
    cmd_valid_o = 1'b0;
    cp = '0;
    emit_cp = 1'b0;

    case (mode_q)
      M_BODY: begin
        if (eoi_i) begin
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
          cmd_o.err_code = ERR_UNTERM; cmd_o.err_offset = open_q;
        end else if (byte_i == "\"") begin
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_CLOSE;
          cmd_o.length = len_q; cmd_o.had_escape = esc_q;
        end else if (byte_i < 8'h20) begin
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
          cmd_o.err_code = ERR_CTRL; cmd_o.err_offset = off32;
        end else if (byte_i == "\\") begin
          esc_d = 1'b1; mark_d = off32; mode_d = M_ESC;
        end else if (byte_i < 8'h80) begin
          cmd_o.n_bytes = 3'd1; cmd_o.bytes[0] = byte_i;
        end else if (llen_in == 2'd0) begin
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
          cmd_o.err_code = ERR_UTF8; cmd_o.err_offset = off32;
        end else begin
          lead_d = byte_i; held_d = '0; rem_d = llen_in;
          mark_d = off32; mode_d = M_UTF8;
        end
      end
      M_ESC: begin
        mode_d = M_BODY;
        cmd_o.n_bytes = 3'd1;
        if (eoi_i) begin
          cmd_o.n_bytes = 3'd0;
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
          cmd_o.err_code = ERR_UNTERM; cmd_o.err_offset = open_q;
        end else begin
          case (byte_i)
            "\"", "\\", "/": cmd_o.bytes[0] = byte_i;
            "b": cmd_o.bytes[0] = 8'h08;
            "f": cmd_o.bytes[0] = 8'h0C;
            "n": cmd_o.bytes[0] = 8'h0A;
            "r": cmd_o.bytes[0] = 8'h0D;
            "t": cmd_o.bytes[0] = 8'h09;
            "u": begin
              cmd_o.n_bytes = 3'd0; mode_d = M_HEX1; hex_d = '0; hcnt_d = '0;
            end
            default: begin
              cmd_o.n_bytes = 3'd0;
              cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
              cmd_o.err_code = ERR_ESCAPE; cmd_o.err_offset = mark_q;
            end
          endcase
        end
      end
      M_HEX1, M_HEX2: begin
        if (!hok) begin
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
          cmd_o.err_code = (mode_q == M_HEX1) ? ERR_HEX : ERR_SURROGATE;
          cmd_o.err_offset = mark_q;
        end else begin
          hex_d = hnew;
          if (hcnt_q != 2'd3) begin
            hcnt_d = hcnt_q + 2'd1;
          end else begin
            hcnt_d = '0;
            if (mode_q == M_HEX1) begin
              if (hnew[15:10] == 6'b110111) begin
                cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
                cmd_o.err_code = ERR_SURROGATE; cmd_o.err_offset = mark_q;
              end else if (hnew[15:10] == 6'b110110) begin
                hs_d = hnew[9:0]; mode_d = M_BS2;
              end else begin
                mode_d = M_BODY; cp = {5'd0, hnew}; emit_cp = 1'b1;
              end
            end else begin
              if (hnew[15:10] != 6'b110111) begin
                cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
                cmd_o.err_code = ERR_SURROGATE; cmd_o.err_offset = mark_q;
              end else begin
                mode_d = M_BODY;
                cp = 21'h10000 + {1'b0, hs_q, hnew[9:0]};
                emit_cp = 1'b1;
              end
            end
          end
        end
      end
      M_BS2, M_U2: begin
        if (eoi_i || byte_i != ((mode_q == M_BS2) ? 8'h5C : 8'h75)) begin
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
          cmd_o.err_code = ERR_SURROGATE; cmd_o.err_offset = mark_q;
        end else if (mode_q == M_BS2) begin
          mode_d = M_U2;
        end else begin
          mode_d = M_HEX2; hex_d = '0; hcnt_d = '0;
        end
      end
      M_UTF8: begin
        if (eoi_i || llen_q == 2'd0 ||
            ((rem_q == llen_q) ? !sec_ok : (byte_i[7:6] != 2'b10))) begin
          cmd_o.has_tail = 1'b1; cmd_o.tail_kind = KIND_ERROR;
          cmd_o.err_code = ERR_UTF8; cmd_o.err_offset = mark_q;
        end else if (rem_q > 2'd1) begin
          held_d = {held_q[7:0], byte_i};
          rem_d = rem_q - 2'd1;
        end else begin
          rem_d = '0;
          cmd_o.n_bytes = {1'b0, llen_q} + 3'd1;
          cmd_o.bytes[0] = lead_q;
          case (llen_q)
            2'd1: cmd_o.bytes[1] = byte_i;
            2'd2: begin cmd_o.bytes[1] = held_q[7:0]; cmd_o.bytes[2] = byte_i; end
            default: begin
              cmd_o.bytes[1] = held_q[15:8]; cmd_o.bytes[2] = held_q[7:0];
              cmd_o.bytes[3] = byte_i;
            end
          endcase
          lead_d = '0; held_d = '0; mode_d = M_BODY;
        end
      end
      default: begin
        if (!eoi_i && byte_i == "\"") begin
          hex_d = '0; hcnt_d = '0; hs_d = '0; lead_d = '0; held_d = '0;
          rem_d = '0; mark_d = '0; len_d = '0; esc_d = 1'b0;
          open_d = off32; mode_d = M_BODY;
        end else begin
          mode_d = M_IDLE;
        end
      end
    endcase

    if (emit_cp) begin
      if (cp < 21'h80) begin
        cmd_o.n_bytes = 3'd1; cmd_o.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        cmd_o.n_bytes = 3'd2;
        cmd_o.bytes[0] = {3'b110, cp[10:6]}; cmd_o.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
        cmd_o.n_bytes = 3'd3;
        cmd_o.bytes[0] = {4'b1110, cp[15:12]}; cmd_o.bytes[1] = {2'b10, cp[11:6]};
        cmd_o.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        cmd_o.n_bytes = 3'd4;
        cmd_o.bytes[0] = {5'b11110, cp[20:18]}; cmd_o.bytes[1] = {2'b10, cp[17:12]};
        cmd_o.bytes[2] = {2'b10, cp[11:6]}; cmd_o.bytes[3] = {2'b10, cp[5:0]};
      end
    end

    // Length counts only while the string stays open; saturate at all ones.
    if (len_q > 32'hFFFF_FFFF - 32'(cmd_o.n_bytes)) len_d = 32'hFFFF_FFFF;
    else len_d = len_d + 32'(cmd_o.n_bytes);

    if (cmd_o.has_tail) begin
      mode_d = M_IDLE; hex_d = '0; hcnt_d = '0; hs_d = '0; lead_d = '0;
      held_d = '0; rem_d = '0; open_d = '0; mark_d = '0; len_d = '0; esc_d = 1'b0;
    end
    cmd_valid_o = step_i && (cmd_o.has_tail || cmd_o.n_bytes != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; hex_q <= '0; hcnt_q <= '0; hs_q <= '0; lead_q <= '0;
      held_q <= '0; rem_q <= '0; open_q <= '0; mark_q <= '0; len_q <= '0;
      esc_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; hex_q <= hex_d; hcnt_q <= hcnt_d; hs_q <= hs_d;
      lead_q <= lead_d; held_q <= held_d; rem_q <= rem_d; open_q <= open_d;
      mark_q <= mark_d; len_q <= len_d; esc_q <= esc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_in_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_UTF8) |-> (rem_q != 2'd0))
    else $error("utf8 sequence with nothing remaining");
  a_nbytes_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (cmd_o.n_bytes <= 3'd4))
    else $error("record carries too many bytes");
  a_tail_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cmd_o.has_tail) |=> (mode_q == M_IDLE))
    else $error("scanner not idle after close or error");
`endif

endmodule

`default_nettype wire

// File: rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short queue of work records between scanner and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue import jsu_pkg::*; #(
  parameter int Depth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  jsu_cmd_t      data_i,
  output      logic     full_o,
  output      logic     empty_o,
  input  wire logic     pop_i,
  output      jsu_cmd_t data_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  jsu_cmd_t        mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/jsu_emitter.sv
// ----------------------------------------------------------------------------
// jsu_emitter
// Back part: unrolls one work record into result items, one per cycle while the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_emitter import jsu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  jsu_cmd_t         cmd_i,
  output      logic        cmd_pop_o,
  output      logic        valid_o,
  input  wire logic        ready_i,
  output      logic [1:0]  result_kind_o,
  output      logic [7:0]  out_byte_o,
  output      logic [2:0]  error_code_o,
  output      logic [31:0] error_offset_o,
  output      logic [31:0] decoded_length_o,
  output      logic        had_escape_o,
  output      logic        last_o
);

  logic [2:0] idx_q;
  logic       is_tail, is_last, load;

  assign is_tail = (idx_q == cmd_i.n_bytes);
  assign is_last = cmd_i.has_tail ? is_tail : (idx_q == cmd_i.n_bytes - 3'd1);
  // Output register is free when empty or being taken this cycle.
  assign load      = cmd_valid_i && (!valid_o || ready_i);
  assign cmd_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0; idx_q <= '0;
    end else begin
      if (load) valid_o <= 1'b1;
      else if (ready_i) valid_o <= 1'b0;
      if (load) idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_o <= is_last;
      if (is_tail) begin
        result_kind_o <= cmd_i.tail_kind; out_byte_o <= '0;
        error_code_o <= cmd_i.err_code; error_offset_o <= cmd_i.err_offset;
        decoded_length_o <= cmd_i.length; had_escape_o <= cmd_i.had_escape;
      end else begin
        result_kind_o <= KIND_DATA; out_byte_o <= cmd_i.bytes[idx_q[1:0]];
        error_code_o <= ERR_NONE; error_offset_o <= '0;
        decoded_length_o <= '0; had_escape_o <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (idx_q <= cmd_i.n_bytes))
    else $error("emitter index beyond record");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> last_o)
    else $error("record finished without last flag");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o)
    else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire
